// ===== hdl/uzs_pkg.sv =====
package uzs_pkg;

  // Bytes of the zero-width joiner, E2 80 8D.
  localparam logic [7:0] JOIN0 = 8'hE2;
  localparam logic [7:0] JOIN1 = 8'h80;
  localparam logic [7:0] JOIN2 = 8'h8D;

  // Longest burst of results that one input byte can cause: a joiner plus a
  // four-byte code point.
  localparam int unsigned CmdBytes = 7;
  localparam int unsigned CmdIdxW  = $clog2(CmdBytes);
  localparam int unsigned CmdCntW  = $clog2(CmdBytes + 1);

  // Command queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_STRAY       = 3'd1,
    ERR_BAD_LEAD    = 3'd2,
    ERR_LEAD_JOINER = 3'd3,
    ERR_TRUNC       = 3'd4
  } uzs_err_e;

  // One command: the run of result beats that one input byte releases.
  typedef struct packed {
    logic [CmdBytes-1:0][7:0] bytes;
    logic [CmdCntW-1:0]       count;  // number of beats, 1 to 7
    logic                     start;  // first beat begins a cluster
    logic                     done;   // last beat closes the string
    uzs_err_e                 err;
  } uzs_cmd_t;

endpackage

// ===== hdl/uzs_if.sv =====
interface uzs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface uzs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       cluster_start;
  logic       string_done;
  logic       run_last;
  logic [2:0] error_code;

  modport source (output valid, output out_byte, output cluster_start, output string_done,
                  output run_last, output error_code, input ready);
  modport sink   (input valid, input out_byte, input cluster_start, input string_done,
                  input run_last, input error_code, output ready);
endinterface

// ===== hdl/uzs_front.sv =====
module uzs_front
  import uzs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  uzs_in_if.sink   in_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output uzs_cmd_t q_cmd_o
);

  logic [2:0][7:0] cp_q;
  logic [2:0]      exp_q, exp_d;
  logic [1:0]      held_q, held_d;
  logic            jp_q, jp_d;
  logic            seen_q, seen_d;

  logic            open_cp;
  logic [2:0]      lead_len;
  uzs_err_e        lead_err;
  logic [2:0]      exp_len;
  logic [1:0]      pos;
  logic [3:0][7:0] cpw;
  logic [2:0]      held_new;
  logic            complete;
  logic            is_joiner;
  logic            cp_we;
  logic            clear;
  uzs_cmd_t        cmd;

  function automatic uzs_cmd_t err_cmd(input uzs_err_e code);
    uzs_cmd_t c;
    c       = '0;
    c.count = CmdCntW'(1);
    c.done  = 1'b1;
    c.err   = code;
    return c;
  endfunction

  assign in_i.ready = !q_full_i;
  assign open_cp    = (exp_q == 3'd0);

  always_comb begin
    lead_len = 3'd0;
    lead_err = ERR_NONE;
    priority if (!in_i.in_byte[7]) begin
      lead_len = 3'd1;
    end else if (in_i.in_byte[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (in_i.in_byte[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (in_i.in_byte[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else if (in_i.in_byte[7:6] == 2'b10) begin
      lead_err = ERR_STRAY;
    end else begin
      lead_err = ERR_BAD_LEAD;
    end
  end

  always_comb begin
    exp_len = open_cp ? lead_len : exp_q;
    pos     = open_cp ? 2'd0 : held_q;
    for (int k = 0; k < 3; k++) begin
      cpw[k] = (pos == 2'(k)) ? in_i.in_byte : cp_q[k];
    end
    cpw[3]    = in_i.in_byte;
    held_new  = {1'b0, pos} + 3'd1;
    complete  = (held_new >= exp_len);
    is_joiner = (exp_len == 3'd3) && (cpw[0] == JOIN0) && (cpw[1] == JOIN1) &&
                (cpw[2] == JOIN2);
  end

  always_comb begin
    q_push_o = 1'b0;
    cmd      = '0;
    exp_d    = exp_q;
    held_d   = held_q;
    jp_d     = jp_q;
    seen_d   = seen_q;
    cp_we    = 1'b0;
    clear    = 1'b0;
    if (in_i.valid && in_i.ready) begin
      if (open_cp && (lead_err != ERR_NONE)) begin
        q_push_o = 1'b1;
        cmd      = err_cmd(lead_err);
        clear    = 1'b1;
      end else if (!complete) begin
        if (in_i.end_of_string) begin
          q_push_o = 1'b1;
          cmd      = err_cmd(ERR_TRUNC);
          clear    = 1'b1;
        end else begin
          exp_d  = exp_len;
          held_d = held_new[1:0];
          cp_we  = 1'b1;
        end
      end else begin
        exp_d  = 3'd0;
        held_d = 2'd0;
        priority if (jp_q && !seen_q) begin
          q_push_o = 1'b1;
          cmd      = err_cmd(ERR_LEAD_JOINER);
          clear    = 1'b1;
        end else if (jp_q) begin
          // The held joiner and this code point join the previous cluster.
          q_push_o     = 1'b1;
          cmd.bytes[0] = JOIN0;
          cmd.bytes[1] = JOIN1;
          cmd.bytes[2] = JOIN2;
          for (int k = 0; k < 4; k++) begin
            cmd.bytes[k+3] = cpw[k];
          end
          cmd.count = CmdCntW'(3'd3 + exp_len);
          cmd.done  = in_i.end_of_string;
          jp_d      = 1'b0;
        end else if (is_joiner) begin
          jp_d = 1'b1;
          if (in_i.end_of_string) begin
            q_push_o     = 1'b1;
            cmd.bytes[0] = JOIN0;
            cmd.bytes[1] = JOIN1;
            cmd.bytes[2] = JOIN2;
            cmd.count    = CmdCntW'(3);
            cmd.start    = 1'b1;
            cmd.done     = 1'b1;
          end
        end else begin
          q_push_o = 1'b1;
          for (int k = 0; k < 4; k++) begin
            cmd.bytes[k] = cpw[k];
          end
          cmd.count = CmdCntW'(exp_len);
          cmd.start = 1'b1;
          cmd.done  = in_i.end_of_string;
          seen_d    = 1'b1;
        end
        if (in_i.end_of_string) begin
          clear = 1'b1;
        end
      end
    end
    if (clear) begin
      exp_d  = 3'd0;
      held_d = 2'd0;
      jp_d   = 1'b0;
      seen_d = 1'b0;
    end
  end

  assign q_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 3'd0;
      held_q <= 2'd0;
      jp_q   <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      exp_q  <= exp_d;
      held_q <= held_d;
      jp_q   <= jp_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cp_we && (pos != 2'd3)) begin
      cp_q[pos] <= in_i.in_byte;
    end
  end

endmodule

// ===== hdl/uzs_queue.sv =====
module uzs_queue
  import uzs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  uzs_cmd_t cmd_i,
  output logic     full_o,
  output logic     valid_o,
  output uzs_cmd_t cmd_o,
  input  logic     pop_i
);

  uzs_cmd_t   slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/uzs_back.sv =====
module uzs_back
  import uzs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  uzs_cmd_t q_cmd_i,
  output logic     q_pop_o,
  uzs_out_if.source out_o
);

  logic [CmdIdxW-1:0] idx_q, idx_d;
  logic               vld_q;
  logic [7:0]         byte_q;
  logic               start_q, done_q, last_q;
  logic [2:0]         err_q;
  logic               load, adv, last;

  assign load    = !vld_q || out_o.ready;
  assign adv     = load && q_valid_i;
  assign last    = (idx_q == CmdIdxW'(q_cmd_i.count - CmdCntW'(1)));
  assign q_pop_o = adv && last;

  always_comb begin
    idx_d = idx_q;
    if (adv) begin
      idx_d = last ? '0 : idx_q + CmdIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        vld_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q  <= q_cmd_i.bytes[idx_q];
      start_q <= q_cmd_i.start && (idx_q == '0);
      done_q  <= last && q_cmd_i.done;
      last_q  <= last;
      err_q   <= q_cmd_i.err;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.cluster_start = start_q;
  assign out_o.string_done   = done_q;
  assign out_o.run_last      = last_q;
  assign out_o.error_code    = err_q;

endmodule

// ===== hdl/utf8_zwj_cluster_splitter_core.sv =====
// UTF-8 cluster splitter with zero-width-joiner joining.
//
// in_i carries one raw byte of a UTF-8 string per beat, with end_of_string
// set on the final byte. out_o carries the bytes back, each marked with
// cluster_start, plus string_done on the last beat of a string and run_last
// on the last beat released by one input byte. An error gives a single
// beat with out_byte zero and a non-zero error_code, and the next byte
// starts a new string.
//
// The front accepts one byte per cycle whenever the four-entry command queue
// has room; bytes of a code point are held until it completes, so one input
// byte releases between none and seven beats. The back sends one beat per
// cycle from its output register while the receiver is ready; a byte that
// completes a code point passes through the queue into that register. Text
// of single-byte code points flows at one byte per cycle in and out while
// the receiver is ready; the back paces longer bursts at one beat per cycle.
//
// Reset clears all string state and empties the queue. When the receiver
// stalls, the output register holds its beat, the queue fills, and the front
// drops in_i.ready once all four queue entries are taken.
module utf8_zwj_cluster_splitter_core
  import uzs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  uzs_in_if.sink    in_i,
  uzs_out_if.source out_o
);

  logic     q_push, q_full, q_valid, q_pop;
  uzs_cmd_t q_wcmd, q_rcmd;

  // The front tracks the open code point and the held joiner, and turns each
  // byte into at most one command.
  uzs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wcmd)
  );

  uzs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wcmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_rcmd),
    .pop_i   (q_pop)
  );

  // The back walks through a command one beat at a time.
  uzs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_rcmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // A command is only retired when one is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Every queued command carries between one and seven beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_wcmd.count != '0) && (q_wcmd.count <= CmdCntW'(CmdBytes)))
    else $error("command with bad beat count");

  // An error beat is a lone, empty beat that closes the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.error_code != ERR_NONE)) |->
      (out_o.out_byte == 8'd0) && !out_o.cluster_start && out_o.string_done &&
      out_o.run_last)
    else $error("malformed error beat");

  // The end of a string is always the end of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.string_done) |-> out_o.run_last)
    else $error("string_done without run_last");

endmodule

// ===== tb/sv/uzs_cluster_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the cluster splitter and checks every output beat
// against its own prediction of the beats that each accepted byte releases.
module uzs_cluster_checker
  import uzs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  uzs_in_if    in_m,
  uzs_out_if   out_m,
  output int   fail_count,
  output int   open_count,
  output int   beats_checked,
  output int   error_beats
);

  typedef struct packed {
    logic [7:0] data;
    logic       starts_cluster;
    logic       ends_string;
    logic       ends_run;
    uzs_err_e   err;
  } cluster_beat_t;

  // Prediction state: the code point being gathered and the joiner status.
  logic [7:0]    cp_buf [4];
  logic [2:0]    cp_len;
  logic [2:0]    cp_got;
  logic          zwj_held;
  logic          cluster_open;

  cluster_beat_t burst [CmdBytes];
  int            burst_n;
  cluster_beat_t beats_due [$];
  cluster_beat_t want;

  initial begin
    fail_count    = 0;
    open_count    = 0;
    beats_checked = 0;
    error_beats   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < 40) begin
      $display("MISMATCH at beat %0d: %s is %0h, expected %0h",
               beats_checked, what, got, exp_val);
    end
    fail_count++;
  endtask

  function automatic void clear_string();
    cp_buf       = '{default: '0};
    cp_len       = '0;
    cp_got       = '0;
    zwj_held     = 1'b0;
    cluster_open = 1'b0;
  endfunction

  function automatic void add_beat(input logic [7:0] d, input logic s);
    burst[burst_n] = '{data: d, starts_cluster: s, ends_string: 1'b0,
                       ends_run: 1'b0, err: ERR_NONE};
    burst_n++;
  endfunction

  function automatic void add_joiner(input logic s);
    add_beat(JOIN0, s);
    add_beat(JOIN1, 1'b0);
    add_beat(JOIN2, 1'b0);
  endfunction

  // Works out the beats that one accepted byte releases and queues them.
  function automatic void split_byte(input logic [7:0] b, input logic eos);
    uzs_err_e   fault;
    logic [2:0] n_cp;
    logic       cp_is_zwj;
    int         k;
    fault   = ERR_NONE;
    burst_n = 0;
    if (cp_got == 3'd0 || cp_len == 3'd0) begin
      cp_got = 3'd0;
      casez (b)
        8'b0???????: cp_len = 3'd1;
        8'b110?????: cp_len = 3'd2;
        8'b1110????: cp_len = 3'd3;
        8'b11110???: cp_len = 3'd4;
        8'b10??????: fault = ERR_STRAY;
        default:     fault = ERR_BAD_LEAD;
      endcase
    end
    if (fault == ERR_NONE) begin
      cp_buf[cp_got[1:0]] = b;
      cp_got = cp_got + 3'd1;
      if (cp_got < cp_len) begin
        if (eos) fault = ERR_TRUNC;
      end else begin
        n_cp   = cp_got;
        cp_got = 3'd0;
        cp_len = 3'd0;
        cp_is_zwj = (n_cp == 3'd3) && (cp_buf[0] == JOIN0) &&
                    (cp_buf[1] == JOIN1) && (cp_buf[2] == JOIN2);
        if (zwj_held) begin
          if (!cluster_open) begin
            fault = ERR_LEAD_JOINER;
          end else begin
            add_joiner(1'b0);
            for (k = 0; k < n_cp; k++) add_beat(cp_buf[k], 1'b0);
            zwj_held = 1'b0;
          end
        end else if (cp_is_zwj) begin
          zwj_held = 1'b1;
        end else begin
          for (k = 0; k < n_cp; k++) add_beat(cp_buf[k], k == 0);
          cluster_open = 1'b1;
        end
        if (fault == ERR_NONE && eos) begin
          // A joiner still held at the end becomes a cluster of its own.
          if (zwj_held) add_joiner(1'b1);
          if (burst_n > 0) burst[burst_n-1].ends_string = 1'b1;
          clear_string();
        end
      end
    end
    if (fault != ERR_NONE) begin
      clear_string();
      burst[0] = '{data: 8'h00, starts_cluster: 1'b0, ends_string: 1'b1,
                   ends_run: 1'b0, err: fault};
      burst_n  = 1;
    end
    if (burst_n > 0) burst[burst_n-1].ends_run = 1'b1;
    for (k = 0; k < burst_n; k++) beats_due.insert(beats_due.size(), burst[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_string();
      beats_due.delete();
      open_count <= 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        beats_checked++;
        if (uzs_err_e'(out_m.error_code) != ERR_NONE) error_beats++;
        if (beats_due.size() == 0) begin
          report_mismatch("beat with nothing expected, byte", out_m.out_byte, 0);
        end else begin
          want = beats_due.pop_front();
          if (out_m.out_byte !== want.data)
            report_mismatch("out_byte", out_m.out_byte, want.data);
          if (out_m.cluster_start !== want.starts_cluster)
            report_mismatch("cluster_start", out_m.cluster_start, want.starts_cluster);
          if (out_m.string_done !== want.ends_string)
            report_mismatch("string_done", out_m.string_done, want.ends_string);
          if (out_m.run_last !== want.ends_run)
            report_mismatch("run_last", out_m.run_last, want.ends_run);
          if (out_m.error_code !== want.err)
            report_mismatch("error_code", out_m.error_code, want.err);
        end
      end
      if (in_m.valid && in_m.ready) split_byte(in_m.in_byte, in_m.end_of_string);
      open_count <= beats_due.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Top of the cluster splitter bench. It makes the byte stream, drives the
// receiver's ready line and gives the verdict; all checking is done by the
// checker instantiated beside the block.
module testbench;
  import uzs_pkg::*;

  // Byte count at which the random part stops, and the point after which
  // neither side idles any more.
  localparam int unsigned StopBytes = 370;
  localparam int unsigned CalmBytes = 310;
  localparam int unsigned MidBytes  = 190;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  logic sink_ready = 1'b0;

  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned src_quiet    = 0;
  int unsigned sink_hold    = 0;
  int unsigned sink_quiet   = 0;

  int fail_count;
  int open_count;
  int beats_checked;
  int error_beats;

  uzs_in_if  in_m ();
  uzs_out_if out_m ();

  assign out_m.ready = sink_ready;

  utf8_zwj_cluster_splitter_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_m),
    .out_o  (out_m)
  );

  uzs_cluster_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_m          (in_m),
    .out_m         (out_m),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .beats_checked (beats_checked),
    .error_beats   (error_beats)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side. Ready drops at random, with occasional stretches in which
  // it stays high throughout. Once the run is in its calm part the receiver
  // never stalls.
  always @(posedge clk) begin
    if (calm) begin
      sink_hold = 0;
    end else if (sink_quiet != 0) begin
      sink_quiet--;
    end else if (sink_hold != 0) begin
      sink_hold--;
    end else begin
      case ($urandom_range(0, 15))
        0, 1:    sink_hold  = $urandom_range(1, 14);
        2:       sink_quiet = $urandom_range(10, 40);
        default: ;
      endcase
    end
    sink_ready <= (sink_hold == 0);
  end

  // Lead byte of a code point of the given length, with random payload bits.
  function automatic logic [7:0] lead_byte(input int unsigned n_bytes);
    case (n_bytes)
      1:       return 8'($urandom_range(8'h00, 8'h7F));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // Continuation bytes are not checked by the block, so now and then any
  // byte at all is placed there.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return {2'b10, 6'($urandom_range(0, 63))};
    return 8'($urandom_range(0, 255));
  endfunction

  // Presents one byte and holds it until the block takes it. Valid stays
  // high into the next byte unless a gap is chosen, in which case it drops
  // for a random burst of cycles right after the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_m.valid         <= 1'b1;
    in_m.in_byte       <= b;
    in_m.end_of_string <= eos;
    @(posedge clk);
    while (!in_m.ready) @(posedge clk);
    bytes_sent++;
    if (eos) strings_sent++;
    if (calm) begin
      src_quiet = 0;
    end else if (src_quiet != 0) begin
      src_quiet--;
    end else if ($urandom_range(0, 40) == 0) begin
      src_quiet = $urandom_range(15, 50);
    end else if ($urandom_range(0, 7) == 0) begin
      in_m.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Sends the first n_sent bytes of a random code point of n_bytes bytes,
  // with end_of_string on the last byte sent when eos is set.
  task automatic send_code_point(input int unsigned n_bytes, input int unsigned n_sent,
                                 input logic eos);
    int unsigned k;
    for (k = 0; k < n_sent; k++) begin
      send_byte((k == 0) ? lead_byte(n_bytes) : cont_byte(), eos && (k == n_sent - 1));
    end
  endtask

  task automatic send_joiner(input logic eos);
    send_byte(JOIN0, 1'b0);
    send_byte(JOIN1, 1'b0);
    send_byte(JOIN2, eos);
  endtask

  // Whole ordinary code points with no end marker, so that a cluster is
  // open before whatever follows.
  task automatic send_plain_points(input int unsigned count);
    int unsigned len;
    repeat (count) begin
      len = $urandom_range(1, 4);
      send_code_point(len, len, 1'b0);
    end
  endtask

  // Holds the stream back until every beat predicted so far has been seen.
  task automatic drain();
    in_m.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // The limit allows for every byte releasing seven beats, each beat meeting
  // the longest stall, and the longest sender gap, several times over.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [8:0]  directed_seq [$];
    logic [8:0]  entry;
    int unsigned mode;
    int unsigned n_cp;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    logic        mid_drained;

    mid_drained        = 1'b0;
    in_m.valid         <= 1'b0;
    in_m.in_byte       <= 8'h00;
    in_m.end_of_string <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Each entry is {end_of_string, byte}:
    //  - the smallest and largest single-byte code points;
    //  - a joiner after a cluster, followed by a four-byte code point,
    //    which gives the longest run of seven beats;
    //  - a lone joiner as a whole string, given back as its own cluster;
    //  - a stray continuation byte, and bad leads with and without the end
    //    marker;
    //  - a string cut short inside a two-byte code point;
    //  - a joiner at the very start followed by another code point;
    //  - a joiner that follows a held joiner and is appended, not held.
    directed_seq = '{
      9'h000, 9'h17F,
      9'h061, {1'b0, JOIN0}, {1'b0, JOIN1}, {1'b0, JOIN2},
      9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
      {1'b0, JOIN0}, {1'b0, JOIN1}, {1'b1, JOIN2},
      9'h080, 9'h0FF, 9'h1F8,
      9'h1C3,
      {1'b0, JOIN0}, {1'b0, JOIN1}, {1'b0, JOIN2}, 9'h041,
      9'h061, {1'b0, JOIN0}, {1'b0, JOIN1}, {1'b0, JOIN2},
      {1'b0, JOIN0}, {1'b0, JOIN1}, {1'b1, JOIN2}
    };
    foreach (directed_seq[k]) begin
      entry = directed_seq[k];
      send_byte(entry[7:0], entry[8]);
    end

    // Let everything drain before the random part starts.
    drain();

    // Random part: mostly well-formed strings with random content, the rest
    // truncated strings, bad leads, leading joiners and raw noise.
    while (bytes_sent < StopBytes) begin
      if (!mid_drained && bytes_sent >= MidBytes) begin
        drain();
        mid_drained = 1'b1;
      end
      if (bytes_sent >= CalmBytes) calm = 1'b1;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        n_cp = $urandom_range(1, 6);
        for (k = 0; k < n_cp; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 3 || (k != 0 && pick < 25)) begin
            send_joiner(k == n_cp - 1);
          end else begin
            len = $urandom_range(1, 4);
            send_code_point(len, len, k == n_cp - 1);
          end
        end
      end else if (mode < 80) begin
        send_plain_points($urandom_range(0, 3));
        len = $urandom_range(2, 4);
        send_code_point(len, $urandom_range(1, len - 1), 1'b1);
      end else if (mode < 88) begin
        send_plain_points($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) begin
          send_byte({2'b10, 6'($urandom_range(0, 63))}, 1'($urandom_range(0, 1)));
        end else begin
          send_byte(8'hF8 | 8'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
      end else if (mode < 92) begin
        send_joiner(1'b0);
        len = $urandom_range(1, 4);
        send_code_point(len, len, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 6) == 0);
        end
      end
    end

    // Wait for the last beats, then give the block time to show any extra.
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input bytes in %0d terminated strings.",
             bytes_sent, strings_sent);
    $display("Checked %0d output beats, %0d of them error beats.",
             beats_checked, error_beats);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
